[hw/rtl/bed_pkg.sv]
// ----------------------------------------------------------------------------
// bed_pkg: shared types and constants for the bump event detector
// Phase codes, command codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bed_pkg;

  // Machine phases, as reported on the result channel
  typedef enum logic [2:0] {
    PH_WAIT     = 3'd0,
    PH_SAMPLE   = 3'd1,
    PH_FILTER   = 3'd2,
    PH_DETECTED = 3'd3,
    PH_HOLD     = 3'd4
  } phase_t;

  // Input beat commands
  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_ACK  = 1'b1
  } cmd_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_WAIT_TICKS      = 2'd0;
  localparam logic [1:0] CFG_SAMPLE_COUNT    = 2'd1;
  localparam logic [1:0] CFG_LEVEL_THRESHOLD = 2'd2;

  // Field widths fixed by the interface
  localparam int unsigned TICK_W = 16;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned THR_W  = 20;
  localparam int unsigned MAG_IN_W = 16;
  localparam int unsigned CFG_W  = 20;
  localparam int unsigned PROD_W = THR_W + CNT_W;

  // Register reset values
  localparam logic [TICK_W-1:0] WAIT_TICKS_RST      = 16'd100;
  localparam logic [CNT_W-1:0]  SAMPLE_COUNT_RST    = 7'd10;
  localparam logic [THR_W-1:0]  LEVEL_THRESHOLD_RST = 20'd16000;

  // Result beat
  typedef struct packed {
    logic   detected;
    phase_t phase;
  } result_t;

endpackage

[hw/rtl/bump_event_detector.sv]
// ----------------------------------------------------------------------------
// bump_event_detector: five-phase bump detector stepped by tick beats
// Waits a configured number of ticks, sums a burst of magnitude samples,
// tests the average against a threshold and latches an event flag until an
// acknowledge beat clears it. One result beat per input beat.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, in_command, in_magnitude | sink
//  out     | out_valid, out_stall, out_detected, out_phase | source
//  cfg     | cfg_we, cfg_index, cfg_wdata            | sink
//
//  One beat per cycle sustained while out_stall stays low; an accepted input
//  passes the input register, then the state update into the result
//  register. The whole step is one pass of compare, add and a 20x7 product.
//  Reset (rst_n low, synchronous) clears phase, counters, flag and loads
//  the register defaults. A two-entry result buffer absorbs out_stall;
//  in_stall rises only when the spare result entry is occupied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bump_event_detector
  import bed_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 64,
  parameter int unsigned MAG_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_command,
  input  logic [MAG_IN_W-1:0] in_magnitude,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_detected,
  output logic [2:0]          out_phase,
  // configuration
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  // Magnitude bits actually used, sum width and sample cap
  localparam int unsigned MAG_W = (MAG_BITS < MAG_IN_W) ? MAG_BITS : MAG_IN_W;
  localparam int unsigned SUM_W = MAG_W + $clog2(MAX_SAMPLES);
  localparam int unsigned CAP_V = (MAX_SAMPLES > 127) ? 127 : MAX_SAMPLES;
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAP_V);
  localparam int unsigned CMP_W = ((SUM_W + 4) > PROD_W) ? (SUM_W + 4) : PROD_W;

  // Configuration registers
  logic [TICK_W-1:0] wait_ticks_r;
  logic [CNT_W-1:0]  sample_count_r;
  logic [THR_W-1:0]  level_threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_ticks_r      <= WAIT_TICKS_RST;
      sample_count_r    <= SAMPLE_COUNT_RST;
      level_threshold_r <= LEVEL_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WAIT_TICKS:      wait_ticks_r      <= cfg_wdata[TICK_W-1:0];
        CFG_SAMPLE_COUNT:    sample_count_r    <= cfg_wdata[CNT_W-1:0];
        CFG_LEVEL_THRESHOLD: level_threshold_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  logic                s1_valid_r;
  cmd_t                s1_cmd_r;
  logic [MAG_W-1:0]    s1_mag_r;
  logic                skid_valid_r;
  logic                in_fire;
  logic                s2_fire;

  assign in_stall = s1_valid_r & skid_valid_r;
  assign in_fire  = in_valid & ~in_stall;
  assign s2_fire  = s1_valid_r & ~skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s2_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r <= cmd_t'(in_command);
      s1_mag_r <= in_magnitude[MAG_W-1:0];
    end
  end

  // Machine state
  phase_t            phase_r,   phase_nxt;
  logic [TICK_W-1:0] tick_r,    tick_nxt;
  logic [CNT_W-1:0]  taken_r,   taken_nxt;
  logic [SUM_W-1:0]  sum_r,     sum_nxt;
  logic              flag_r,    flag_nxt;

  // Effective sample count: zero reads as one, clamp to the cap
  logic [CNT_W-1:0]  eff_cnt;
  logic [PROD_W-1:0] thr_prod;
  logic              above;

  always_comb begin
    if (sample_count_r == '0) begin
      eff_cnt = CNT_W'(1);
    end else if (sample_count_r > CNT_CAP) begin
      eff_cnt = CNT_CAP;
    end else begin
      eff_cnt = sample_count_r;
    end
  end

  // Exact average test: sum * 16 > threshold * count
  assign thr_prod = PROD_W'(level_threshold_r) * PROD_W'(eff_cnt);
  assign above    = (CMP_W'(sum_r) << 4) > CMP_W'(thr_prod);

  // Next state for one beat
  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    taken_nxt = taken_r;
    sum_nxt   = sum_r;
    flag_nxt  = flag_r;
    if (s1_cmd_r == CMD_ACK) begin
      flag_nxt = 1'b0;
    end else begin
      case (phase_r)
        PH_WAIT: begin
          tick_nxt  = tick_r + TICK_W'(1);
          taken_nxt = '0;
          sum_nxt   = '0;
          if (tick_nxt == wait_ticks_r) phase_nxt = PH_SAMPLE;
        end
        PH_SAMPLE: begin
          tick_nxt  = '0;
          sum_nxt   = sum_r + SUM_W'(s1_mag_r);
          taken_nxt = taken_r + CNT_W'(1);
          if (taken_nxt >= eff_cnt) phase_nxt = PH_FILTER;
        end
        PH_FILTER: begin
          phase_nxt = above ? PH_DETECTED : PH_WAIT;
        end
        PH_DETECTED: begin
          flag_nxt  = 1'b1;
          phase_nxt = PH_HOLD;
        end
        PH_HOLD: begin
          if (!flag_r) phase_nxt = PH_WAIT;
        end
        default: begin
          phase_nxt = PH_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      tick_r  <= '0;
      taken_r <= '0;
      sum_r   <= '0;
      flag_r  <= 1'b0;
    end else if (s2_fire) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      taken_r <= taken_nxt;
      sum_r   <= sum_nxt;
      flag_r  <= flag_nxt;
    end
  end

  // Result buffer: main entry plus one spare
  result_t res_new;
  result_t out_r;
  result_t skid_r;
  logic    out_valid_r;
  logic    out_fire;

  assign res_new.detected = flag_nxt;
  assign res_new.phase    = phase_nxt;
  assign out_fire         = out_valid_r & ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) skid_valid_r <= 1'b0;
    end else if (s2_fire) begin
      if (out_valid_r && !out_fire) skid_valid_r <= 1'b1;
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) out_r <= skid_r;
    end else if (s2_fire) begin
      if (out_valid_r && !out_fire) begin
        skid_r <= res_new;
      end else begin
        out_r <= res_new;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_detected = out_r.detected;
  assign out_phase    = out_r.phase;

  // Checks
  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("spare result entry full while main entry empty");

  a_taken_capped: assert property (@(posedge clk) disable iff (!rst_n)
    taken_r <= CNT_CAP)
    else $error("sample counter beyond cap");

  a_detect_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && s1_cmd_r == CMD_TICK && phase_r == PH_DETECTED)
      |=> (flag_r && phase_r == PH_HOLD))
    else $error("detected phase did not latch the flag");

  a_filter_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && s1_cmd_r == CMD_TICK && phase_r == PH_FILTER)
      |=> (phase_r == PH_DETECTED || phase_r == PH_WAIT))
    else $error("filter phase left to an unexpected phase");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room in the result buffer");

endmodule

[sim/bump_event_detector_tb.sv]
// ----------------------------------------------------------------------------
// bump_event_detector_tb: self-checking bench for the bump event detector
// Drives tick and acknowledge beats with random gaps and result stalls,
// tracks the wait/sample/filter/detected/hold machine in a local model and
// checks every result beat against it. Register settings are changed
// between bursts, including a wait below the running count and burst resizing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bump_event_detector_tb;
  import bed_pkg::*;

  localparam int unsigned MAX_SAMPLES      = 64;
  localparam int unsigned CYCLE_LIMIT      = 1_000_000;
  localparam int unsigned SHOWN_MISMATCHES = 10;
  localparam int unsigned THR_MAX          = (1 << THR_W) - 1;

  // DUT ports, all inputs known from time zero
  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic                in_command   = CMD_TICK;
  logic [MAG_IN_W-1:0] in_magnitude = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic                out_detected;
  logic [2:0]          out_phase;
  logic                cfg_we       = 1'b0;
  logic [1:0]          cfg_index    = CFG_WAIT_TICKS;
  logic [CFG_W-1:0]    cfg_wdata    = '0;

  bump_event_detector #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .MAG_BITS   (16)
  ) uut (.*);

  // Register shadow
  logic [TICK_W-1:0] reg_wait_ticks   = WAIT_TICKS_RST;
  logic [CNT_W-1:0]  reg_sample_count = SAMPLE_COUNT_RST;
  logic [THR_W-1:0]  reg_threshold    = LEVEL_THRESHOLD_RST;

  // Detector state as tracked by the bench
  phase_t            ph      = PH_WAIT;
  logic [TICK_W-1:0] ticks   = '0;
  logic [CNT_W-1:0]  taken   = '0;
  longint unsigned   mag_sum = 0;
  logic              flag    = 1'b0;

  result_t     expected_status[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          calm           = 1'b0;  // no gaps, no stalls while set

  initial begin
    forever #10 clk = ~clk;
  end

  // Samples per burst after clamping to 1..MAX_SAMPLES
  function automatic int unsigned burst_len();
    int unsigned n;
    n = reg_sample_count;
    if (n == 0) n = 1;
    if (n > MAX_SAMPLES) n = MAX_SAMPLES;
    return n;
  endfunction

  // Step the tracked machine by one accepted beat and queue the status it gives
  function automatic void detector_advance(input cmd_t cmd, input logic [MAG_IN_W-1:0] mag);
    result_t r;
    if (cmd == CMD_ACK) begin
      flag = 1'b0;
    end else begin
      case (ph)
        PH_WAIT: begin
          ticks   = ticks + 1'b1;
          taken   = '0;
          mag_sum = 0;
          if (ticks == reg_wait_ticks) ph = PH_SAMPLE;
        end
        PH_SAMPLE: begin
          ticks   = '0;
          mag_sum = mag_sum + mag;
          taken   = taken + 1'b1;
          if (taken >= burst_len()) ph = PH_FILTER;
        end
        PH_FILTER: begin
          if (mag_sum * 16 > 64'(reg_threshold) * burst_len()) ph = PH_DETECTED;
          else ph = PH_WAIT;
        end
        PH_DETECTED: begin
          flag = 1'b1;
          ph   = PH_HOLD;
        end
        PH_HOLD: begin
          if (!flag) ph = PH_WAIT;
        end
        default: ph = PH_WAIT;
      endcase
    end
    r.detected = flag;
    r.phase    = ph;
    expected_status.push_back(r);
  endfunction

  // Present one beat, hold it until accepted, then update the model
  task automatic send_beat(input cmd_t cmd, input logic [MAG_IN_W-1:0] mag);
    if (!calm && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_magnitude <= mag;
    do @(posedge clk); while (in_stall);
    detector_advance(cmd, mag);
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_WAIT_TICKS:      reg_wait_ticks   = val[TICK_W-1:0];
      CFG_SAMPLE_COUNT:    reg_sample_count = val[CNT_W-1:0];
      CFG_LEVEL_THRESHOLD: reg_threshold    = val[THR_W-1:0];
      default: ;
    endcase
  endtask

  // Drive the machine to the start of a fresh wait phase
  task automatic settle_to_wait();
    while (!(ph == PH_WAIT && ticks == 0))
      send_beat((ph == PH_HOLD && flag) ? CMD_ACK : CMD_TICK, 16'($urandom));
  endtask

  // Random beats: acks mostly where they release the hold phase,
  // magnitudes mostly clustered around a center near the threshold
  task automatic run_bursts(input int n, input int center, input int spread);
    int   m;
    cmd_t c;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_idle();
      if (ph == PH_HOLD && flag) c = $urandom_range(0, 1) ? CMD_ACK : CMD_TICK;
      else c = ($urandom_range(0, 99) < 6) ? CMD_ACK : CMD_TICK;
      if ($urandom_range(0, 99) < 70) begin
        m = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (m < 0) m = 0;
        if (m > 65535) m = 65535;
      end else begin
        m = int'($urandom_range(0, 65535));
      end
      send_beat(c, m[MAG_IN_W-1:0]);
    end
  endtask

  // Reset values: 100-tick wait, 10 samples, threshold 16000 (avg 1000)
  task automatic test_register_defaults();
    run_bursts(150, 1000, 1000);
  endtask

  task automatic test_directed();
    settle_to_wait();
    wait_idle();
    write_reg(CFG_WAIT_TICKS, 1);
    write_reg(CFG_SAMPLE_COUNT, 1);
    write_reg(CFG_LEVEL_THRESHOLD, 0);
    send_beat(CMD_ACK, 16'hFFFF);   // ack while waiting
    send_beat(CMD_TICK, 16'hFFFF);  // magnitude ignored in wait
    send_beat(CMD_TICK, 16'h0000);  // zero sum
    send_beat(CMD_ACK, 16'h0000);   // ack in filter keeps phase
    send_beat(CMD_TICK, 16'h0000);  // 0 > 0 fails, back to wait
    send_beat(CMD_TICK, 16'h0000);
    send_beat(CMD_TICK, 16'hFFFF);
    send_beat(CMD_TICK, 16'h0000);  // event
    send_beat(CMD_ACK, 16'h0000);   // ack in detected, overridden by next tick
    send_beat(CMD_TICK, 16'h0000);  // flag set, hold
    repeat (2) send_beat(CMD_TICK, 16'hFFFF);
    send_beat(CMD_ACK, 16'h0000);
    send_beat(CMD_TICK, 16'h0000);  // hold released
    // average exactly equal to threshold: no event
    wait_idle();
    write_reg(CFG_LEVEL_THRESHOLD, {16'hABCD, 4'h0});
    repeat (3) send_beat(CMD_TICK, 16'hABCD);
    // one LSB lower: event
    wait_idle();
    write_reg(CFG_LEVEL_THRESHOLD, {16'hABCD, 4'h0} - 1'b1);
    repeat (4) send_beat(CMD_TICK, 16'hABCD);
    send_beat(CMD_ACK, 16'h5432);
    send_beat(CMD_TICK, 16'h0000);
  endtask

  // Sample count lowered below the samples already taken mid-burst
  task automatic test_burst_resize();
    settle_to_wait();
    wait_idle();
    write_reg(CFG_SAMPLE_COUNT, 8);
    send_beat(CMD_TICK, 16'($urandom));
    repeat (5) send_beat(CMD_TICK, 16'($urandom));
    wait_idle();
    write_reg(CFG_SAMPLE_COUNT, 3);
    repeat (2) send_beat(CMD_TICK, 16'($urandom));
  endtask

  // Wait ticks set to zero, then below the running count: the counter keeps
  // going and the burst starts only when it meets the register again
  task automatic test_wait_wrap();
    settle_to_wait();
    wait_idle();
    write_reg(CFG_WAIT_TICKS, 6);
    repeat (4) send_beat(CMD_TICK, 16'($urandom));
    wait_idle();
    write_reg(CFG_WAIT_TICKS, 0);
    calm = 1'b1;
    repeat (60) send_beat(CMD_TICK, 16'($urandom));
    wait_idle();
    write_reg(CFG_WAIT_TICKS, 2);
    repeat (20) send_beat(CMD_TICK, 16'($urandom));
    wait_idle();
    write_reg(CFG_WAIT_TICKS, CFG_W'(ticks) + CFG_W'(3));
    while (ph == PH_WAIT) send_beat(CMD_TICK, 16'($urandom));
    calm = 1'b0;
    repeat (3) send_beat(CMD_TICK, 16'($urandom));
  endtask

  // Several register settings, extremes first, random after
  task automatic test_config_sweep();
    int          center;
    int          spread;
    int          thr;
    int unsigned cnt;
    int unsigned wt;
    for (int k = 0; k < 8; k++) begin
      wait_idle();
      center = int'($urandom_range(0, 65535));
      spread = int'($urandom_range(0, 2000));
      thr    = center * 16 + int'($urandom_range(0, 64)) - 32;
      if (thr < 0) thr = 0;
      if (thr > THR_MAX) thr = THR_MAX;
      cnt = $urandom_range(2, 12);
      case (k)
        0: begin  // count saturates at the max, full-scale magnitudes, max threshold
          cnt    = 127;
          center = 65535;
          spread = 50;
          thr    = THR_MAX;
        end
        1: begin  // count zero acts as one, zero threshold
          cnt    = 0;
          center = 0;
          spread = 3;
          thr    = 0;
        end
        2: cnt = MAX_SAMPLES;
        3: cnt = 1;
        default: ;
      endcase
      if (k == 2) write_reg(CFG_WAIT_TICKS, 16'hFFFF);
      // keep the new wait above a running count so no wrap is forced here
      wt = $urandom_range(1, 6);
      if (ph == PH_WAIT && ticks >= wt) wt = ticks + 1;
      write_reg(CFG_WAIT_TICKS, wt);
      write_reg(CFG_SAMPLE_COUNT, cnt);
      write_reg(CFG_LEVEL_THRESHOLD, thr);
      run_bursts(130, center, spread);
    end
  endtask

  // Result checking and random result stalls
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOWN_MISMATCHES)
          $display("%0t: unexpected result beat detected=%0b phase=%0d",
                   $realtime, out_detected, out_phase);
      end else begin
        want = expected_status.pop_front();
        if (out_detected !== want.detected || out_phase !== want.phase) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_MISMATCHES)
            $display("%0t: expected detected=%0b phase=%0d, got detected=%0b phase=%0d",
                     $realtime, want.detected, want.phase, out_detected, out_phase);
        end
      end
    end
    out_stall <= !calm && ($urandom_range(0, 99) < 25);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_defaults();
    test_directed();
    test_burst_resize();
    test_wait_wrap();
    test_config_sweep();
    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && expected_status.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
